FILE: hdl/ldrf_pkg.sv
// shared types, constants and microcode table of the led driver refresh framer
package ldrf_pkg;

    localparam logic [1:0] CMD_WRITE   = 2'd0;
    localparam logic [1:0] CMD_FILL    = 2'd1;
    localparam logic [1:0] CMD_REFRESH = 2'd2;

    localparam logic [2:0] GRID_COUNT  = 3'd6;
    localparam logic [7:0] DATA_CMD    = 8'h40;
    localparam logic [7:0] ADDR_CMD    = 8'hC0;
    localparam logic [7:0] CTRL_OFF    = 8'h80;
    localparam logic [7:0] CTRL_BASE   = 8'h88;
    localparam logic [3:0] LEVEL_MAX   = 4'd8;
    localparam logic [3:0] LEVEL_RESET = 4'd8;

    typedef logic [2:0] t_step;

    localparam t_step STEP_DISPATCH = 3'd0;
    localparam t_step STEP_WRITE    = 3'd1;
    localparam t_step STEP_DATA     = 3'd2;
    localparam t_step STEP_ADDR     = 3'd3;
    localparam t_step STEP_BYTES    = 3'd4;
    localparam t_step STEP_CTRL     = 3'd5;
    localparam t_step STEP_FILL     = 3'd6;

    typedef struct packed {
        logic [1:0] cmd;
        logic [2:0] grid;
        logic [7:0] seg_byte;
    } t_in_req;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       frame_start;
        logic       frame_end;
        logic       last;
    } t_out_req;

    typedef enum logic [1:0] {
        SRC_DATA,
        SRC_ADDR,
        SRC_RAM,
        SRC_CTRL
    } t_src;

    typedef enum logic [1:0] {
        WR_NONE,
        WR_GRID,
        WR_IDX
    } t_wr;

    typedef enum logic [1:0] {
        IDX_HOLD,
        IDX_CLR,
        IDX_INC
    } t_idx_op;

    typedef enum logic [1:0] {
        JMP_NEXT,
        JMP_GOTO,
        JMP_LOOP,
        JMP_DISPATCH
    } t_jmp;

    typedef struct packed {
        logic    emit;
        t_src    src;
        logic    fs;
        logic    fe;
        logic    fl;
        t_wr     wr;
        t_idx_op idx_op;
        t_jmp    jmp;
        t_step   target;
    } t_uword;

    typedef struct packed {
        logic idx_last;
        logic stall;
    } t_dp_stat;

    // control store: one word per step
    function automatic t_uword ucode_rom(input t_step step);
        t_uword w;
        w = '{emit: 1'b0, src: SRC_DATA, fs: 1'b0, fe: 1'b0, fl: 1'b0,
              wr: WR_NONE, idx_op: IDX_HOLD, jmp: JMP_GOTO, target: STEP_DISPATCH};
        unique case (step)
            STEP_DISPATCH: begin
                w.idx_op = IDX_CLR;
                w.jmp    = JMP_DISPATCH;
            end
            STEP_WRITE: begin
                w.wr = WR_GRID;
            end
            STEP_DATA: begin
                w.emit = 1'b1;
                w.src  = SRC_DATA;
                w.fs   = 1'b1;
                w.fe   = 1'b1;
                w.jmp  = JMP_NEXT;
            end
            STEP_ADDR: begin
                w.emit = 1'b1;
                w.src  = SRC_ADDR;
                w.fs   = 1'b1;
                w.jmp  = JMP_NEXT;
            end
            STEP_BYTES: begin
                w.emit   = 1'b1;
                w.src    = SRC_RAM;
                w.idx_op = IDX_INC;
                w.jmp    = JMP_LOOP;
                w.target = STEP_CTRL;
            end
            STEP_CTRL: begin
                w.emit = 1'b1;
                w.src  = SRC_CTRL;
                w.fs   = 1'b1;
                w.fe   = 1'b1;
                w.fl   = 1'b1;
            end
            STEP_FILL: begin
                w.wr     = WR_IDX;
                w.idx_op = IDX_INC;
                w.jmp    = JMP_LOOP;
            end
            default: begin
            end
        endcase
        return w;
    endfunction

    // display control byte from the brightness level
    function automatic logic [7:0] control_byte(input logic [3:0] lvl);
        logic [3:0] l;
        l = (lvl > LEVEL_MAX) ? LEVEL_MAX : lvl;
        if (lvl == 4'd0) begin
            return CTRL_OFF;
        end
        return 8'(CTRL_BASE + {4'd0, l} - 8'd1);
    endfunction

endpackage

FILE: hdl/ldrf_seq.sv
// microcode sequencer: step counter, control store fetch and jumps
module ldrf_seq
    import ldrf_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_accept,
    input  logic [1:0] i_cmd,
    input  t_dp_stat   i_stat,
    output t_uword     o_uword,
    output logic       o_in_ready
);

    t_step  r_step;
    t_step  n_step;
    t_uword uw;

    assign uw         = ucode_rom(r_step);
    assign o_uword    = uw;
    assign o_in_ready = (r_step == STEP_DISPATCH);

    always_comb begin
        n_step = r_step;
        if (!i_stat.stall) begin
            unique case (uw.jmp)
                JMP_NEXT: n_step = 3'(r_step + 3'd1);
                JMP_GOTO: n_step = uw.target;
                JMP_LOOP: n_step = i_stat.idx_last ? uw.target : r_step;
                JMP_DISPATCH: begin
                    if (i_in_accept) begin
                        unique case (i_cmd)
                            CMD_WRITE:   n_step = STEP_WRITE;
                            CMD_FILL:    n_step = STEP_FILL;
                            CMD_REFRESH: n_step = STEP_DATA;
                            default:     n_step = STEP_DISPATCH;
                        endcase
                    end
                end
                default: n_step = STEP_DISPATCH;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= STEP_DISPATCH;
        end else begin
            r_step <= n_step;
        end
    end

endmodule

FILE: hdl/ldrf_dpath.sv
// datapath: display image, byte index, brightness register and output register
module ldrf_dpath
    import ldrf_pkg::*;
#(
    parameter int BUF_BYTES = 12
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_accept,
    input  t_in_req    i_in_req,
    input  logic       i_cfg_we,
    input  logic [3:0] i_cfg_wdata,
    input  t_uword     i_uword,
    output t_dp_stat   o_stat,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output t_out_req   o_out_req
);

    localparam int IDX_W = $clog2(BUF_BYTES);
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(BUF_BYTES - 1);

    logic [7:0]       r_ram [BUF_BYTES];
    logic [IDX_W-1:0] r_idx;
    logic [3:0]       r_bright;
    t_in_req          r_item;
    logic             r_out_valid;
    t_out_req         r_out;

    t_out_req         n_out;
    logic [7:0]       rd_byte;
    logic [IDX_W-1:0] grid_addr;
    logic             idx_last;
    logic             out_free;
    logic             stall;

    assign rd_byte   = r_ram[r_idx];
    assign grid_addr = IDX_W'({r_item.grid, 1'b0});
    assign idx_last  = (r_idx == IDX_LAST);
    assign out_free  = !r_out_valid || i_out_ready;
    assign stall     = i_uword.emit && !out_free;

    assign o_stat.idx_last = idx_last;
    assign o_stat.stall    = stall;

    always_comb begin
        n_out.frame_start = i_uword.fs;
        n_out.last        = i_uword.fl;
        n_out.frame_end   = i_uword.fe;
        unique case (i_uword.src)
            SRC_DATA: n_out.out_byte = DATA_CMD;
            SRC_ADDR: n_out.out_byte = ADDR_CMD;
            SRC_RAM: begin
                n_out.out_byte  = rd_byte;
                n_out.frame_end = idx_last;
            end
            SRC_CTRL: n_out.out_byte = control_byte(r_bright);
            default:  n_out.out_byte = DATA_CMD;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < BUF_BYTES; i++) begin
                r_ram[i] <= 8'd0;
            end
            r_idx       <= '0;
            r_bright    <= LEVEL_RESET;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_bright <= i_cfg_wdata;
            end
            if (i_in_accept) begin
                r_item <= i_in_req;
            end
            if (!stall) begin
                unique case (i_uword.wr)
                    WR_GRID: begin
                        if (r_item.grid < GRID_COUNT) begin
                            r_ram[grid_addr] <= r_item.seg_byte;
                        end
                    end
                    WR_IDX:  r_ram[r_idx] <= r_item.seg_byte;
                    default: begin
                    end
                endcase
                unique case (i_uword.idx_op)
                    IDX_CLR: r_idx <= '0;
                    IDX_INC: r_idx <= IDX_W'(r_idx + 1'b1);
                    default: begin
                    end
                endcase
            end
            if (i_uword.emit && out_free) begin
                r_out_valid <= 1'b1;
                r_out       <= n_out;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_req   = r_out;

endmodule

FILE: hdl/led_driver_refresh_framer.sv
// top level of the led driver refresh framer
//
// keeps an image of the driver display ram and turns refresh requests into
// the framed byte stream for a three-wire led driver, lsb first downstream
// input channel: i_in_valid / o_in_ready with i_in_req (cmd, grid, seg_byte)
//   write stores seg_byte at byte grid*2 (grids 6 and up ignored), fill sets
//   every byte, refresh emits the byte stream, unused code does nothing
// output channel: o_out_valid / i_out_ready with o_out_req, one byte per request
//   refresh gives 0x40 alone, 0xC0 plus every image byte, then the control byte
// config: i_cfg_we / i_cfg_wdata set the brightness level, reset value 8
// sequence: a request is taken in the dispatch step of the microcode sequencer,
//   write runs the write step, fill writes every byte in turn, refresh runs the
//   data, addr, bytes and ctrl steps; bytes leave through the output register
// the single output register gives one byte a cycle while i_out_ready is high
// a stalled receiver holds the output register and the sequencer's emit steps
// reset clears the image, the sequencer and the output valid flag at once
module led_driver_refresh_framer
    import ldrf_pkg::*;
#(
    parameter int BUF_BYTES = 12
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  t_in_req    i_in_req,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output t_out_req   o_out_req,
    input  logic       i_cfg_we,
    input  logic [3:0] i_cfg_wdata
);

    t_uword   uword;
    t_dp_stat stat;
    logic     in_accept;

    // request taken only while the sequencer sits in dispatch
    assign in_accept = i_in_valid && o_in_ready;

    // program counter and control store
    ldrf_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_accept (in_accept),
        .i_cmd       (i_in_req.cmd),
        .i_stat      (stat),
        .o_uword     (uword),
        .o_in_ready  (o_in_ready)
    );

    // image store, index counter and output register
    ldrf_dpath #(
        .BUF_BYTES (BUF_BYTES)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_accept (in_accept),
        .i_in_req    (i_in_req),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_uword     (uword),
        .o_stat      (stat),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_req   (o_out_req)
    );

endmodule
